// File: sv/pvp_pkg.sv
// ----------------------------------------------------------------------------
// pvp_pkg
// Shared types, constants and fixed-point helpers of the vertex projector.
// ----------------------------------------------------------------------------
package pvp_pkg;

	localparam logic [1:0] REG_HORIZ = 2'd0;
	localparam logic [1:0] REG_VERT  = 2'd1;
	localparam logic [1:0] REG_SCRN  = 2'd2;
	localparam logic [1:0] REG_DIST  = 2'd3;

	localparam logic signed [31:0] RST_HORIZ = 32'sd1966080;
	localparam logic signed [31:0] RST_VERT  = 32'sd1310720;
	localparam logic signed [31:0] RST_SCRN  = 32'sd0;
	localparam logic signed [31:0] RST_DIST  = 32'sd1966080;

	localparam logic signed [31:0] FX_PI      = 32'sd205887;
	localparam logic signed [31:0] FX_TWO_PI  = 32'sd411775;
	localparam logic signed [31:0] FX_HALF_PI = 32'sd102944;
	localparam logic signed [31:0] FX_CX      = 32'sh00A0_0000;
	localparam logic signed [31:0] FX_CY      = 32'sh0064_0000;

	localparam logic signed [15:0] MAX_DEG  = 16'sd360;
	localparam logic [31:0]        RAD_MUL  = 32'd3430;

	// reciprocals for division by 3, 6, 120 and 5040; exact for magnitudes below 2^28
	localparam logic [28:0] REC_RAD = 29'd357913942;
	localparam logic [28:0] REC_X3  = 29'd357913942;
	localparam logic [28:0] REC_X5  = 29'd286331154;
	localparam logic [28:0] REC_X7  = 29'd436314139;
	localparam int          SH_RAD  = 30;
	localparam int          SH_X3   = 31;
	localparam int          SH_X5   = 35;
	localparam int          SH_X7   = 41;

	// 100.0 in Q16.16, shifted up by 16 for the reciprocal
	localparam int              DIV_BITS    = 39;
	localparam logic [DIV_BITS-1:0] DIV_DIVIDEND = 39'h64_0000_0000;

	typedef struct packed {
		logic signed [31:0] sh;
		logic signed [31:0] ch;
		logic signed [31:0] sv;
		logic signed [31:0] cv;
		logic signed [31:0] sw;
		logic signed [31:0] cw;
		logic signed [31:0] chcv;
		logic signed [31:0] shcv;
		logic signed [31:0] chsv;
		logic signed [31:0] shsv;
	} coef_t;

	function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p[47:16];
	endfunction

endpackage

// File: sv/pvp_coef.sv
// ----------------------------------------------------------------------------
// pvp_coef
// Sequencer that turns the angle registers into sine, cosine and product
// coefficients with one shared multiplier and reciprocal constant division.
// ----------------------------------------------------------------------------
module pvp_coef (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                restart,
	input  logic signed [31:0]  horiz,
	input  logic signed [31:0]  vert,
	input  logic signed [31:0]  scrn,
	output pvp_pkg::coef_t      coef,
	output logic                busy
);

	localparam logic [3:0] ST_RAD  = 4'd0;
	localparam logic [3:0] ST_X2   = 4'd1;
	localparam logic [3:0] ST_X3   = 4'd2;
	localparam logic [3:0] ST_X5   = 4'd3;
	localparam logic [3:0] ST_X7   = 4'd4;
	localparam logic [3:0] ST_D3   = 4'd5;
	localparam logic [3:0] ST_D5   = 4'd6;
	localparam logic [3:0] ST_D7   = 4'd7;
	localparam logic [3:0] ST_PROD = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	logic [3:0]         state_q;
	logic [2:0]         job_q;
	logic [1:0]         pc_q;
	logic signed [31:0] a_q, x2_q, x3_q, x5_q, x7_q, acc_q;
	pvp_pkg::coef_t     coef_q;

	logic               dv_run_q;
	logic               dv_cnt_q;
	logic [31:0]        dv_mag_q;
	logic [31:0]        dv_quo_q;
	logic               dv_neg_q;

	logic signed [31:0] ang, mul_a, mul_b, mul_r, dv_src, dv_res, a0, rad_div;
	logic signed [15:0] deg16;
	logic [8:0]         deg;
	logic [28:0]        dv_rec;
	logic [63:0]        dv_prod;
	logic [31:0]        dv_quo;
	logic               dv_done;

	always_comb begin
		case (job_q[2:1])
			2'd0:    ang = horiz;
			2'd1:    ang = vert;
			default: ang = scrn;
		endcase
		deg16 = ang[31:16];
		if (deg16 < 16'sd0)
			deg = 9'd0;
		else if (deg16 > pvp_pkg::MAX_DEG)
			deg = 9'd360;
		else
			deg = deg16[8:0];
		rad_div = $signed(32'(deg) * pvp_pkg::RAD_MUL + 32'd1);
	end

	always_comb begin
		case (state_q)
			ST_D3:   begin dv_src = x3_q;    dv_rec = pvp_pkg::REC_X3;  end
			ST_D5:   begin dv_src = x5_q;    dv_rec = pvp_pkg::REC_X5;  end
			ST_D7:   begin dv_src = x7_q;    dv_rec = pvp_pkg::REC_X7;  end
			default: begin dv_src = rad_div; dv_rec = pvp_pkg::REC_RAD; end
		endcase
		dv_prod = 64'(dv_mag_q) * 64'(dv_rec);
		case (state_q)
			ST_D3:   dv_quo = 32'(dv_prod >> pvp_pkg::SH_X3);
			ST_D5:   dv_quo = 32'(dv_prod >> pvp_pkg::SH_X5);
			ST_D7:   dv_quo = 32'(dv_prod >> pvp_pkg::SH_X7);
			default: dv_quo = 32'(dv_prod >> pvp_pkg::SH_RAD);
		endcase
		dv_done = dv_run_q && dv_cnt_q;
		dv_res  = dv_neg_q ? -$signed(dv_quo_q) : $signed(dv_quo_q);
		a0      = dv_res + (job_q[0] ? pvp_pkg::FX_HALF_PI : 32'sd0);
		if (a0 > pvp_pkg::FX_PI)
			a0 = a0 - pvp_pkg::FX_TWO_PI;
	end

	always_comb begin
		case (state_q)
			ST_X2:   begin mul_a = a_q;  mul_b = a_q;  end
			ST_X3:   begin mul_a = x2_q; mul_b = a_q;  end
			ST_X5:   begin mul_a = x3_q; mul_b = x2_q; end
			ST_X7:   begin mul_a = x5_q; mul_b = x2_q; end
			ST_PROD: begin
				case (pc_q)
					2'd0:    begin mul_a = coef_q.ch; mul_b = coef_q.cv; end
					2'd1:    begin mul_a = coef_q.sh; mul_b = coef_q.cv; end
					2'd2:    begin mul_a = coef_q.ch; mul_b = coef_q.sv; end
					default: begin mul_a = coef_q.sh; mul_b = coef_q.sv; end
				endcase
			end
			default: begin mul_a = a_q;  mul_b = a_q;  end
		endcase
		mul_r = pvp_pkg::fmul(mul_a, mul_b);
	end

	// constant divider: load magnitude, multiply by reciprocal, apply sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_run_q <= 1'b0;
			dv_cnt_q <= 1'b0;
		end else if (restart || dv_done) begin
			dv_run_q <= 1'b0;
			dv_cnt_q <= 1'b0;
		end else if (state_q == ST_RAD || state_q == ST_D3 || state_q == ST_D5 ||
				state_q == ST_D7) begin
			dv_run_q <= 1'b1;
			if (dv_run_q)
				dv_cnt_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!dv_run_q) begin
			dv_neg_q <= dv_src[31];
			dv_mag_q <= dv_src[31] ? 32'(-dv_src) : dv_src;
		end else if (!dv_cnt_q) begin
			dv_quo_q <= dv_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RAD;
			job_q   <= '0;
			pc_q    <= '0;
		end else if (restart) begin
			state_q <= ST_RAD;
			job_q   <= '0;
			pc_q    <= '0;
		end else begin
			case (state_q)
				ST_RAD:  if (dv_done) state_q <= ST_X2;
				ST_X2:   state_q <= ST_X3;
				ST_X3:   state_q <= ST_X5;
				ST_X5:   state_q <= ST_X7;
				ST_X7:   state_q <= ST_D3;
				ST_D3:   if (dv_done) state_q <= ST_D5;
				ST_D5:   if (dv_done) state_q <= ST_D7;
				ST_D7: begin
					if (dv_done) begin
						if (job_q == 3'd5) begin
							state_q <= ST_PROD;
						end else begin
							job_q   <= job_q + 3'd1;
							state_q <= ST_RAD;
						end
					end
				end
				ST_PROD: begin
					pc_q <= pc_q + 2'd1;
					if (pc_q == 2'd3)
						state_q <= ST_DONE;
				end
				ST_DONE: state_q <= ST_DONE;
				default: state_q <= ST_RAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_RAD: if (dv_done) a_q <= a0;
			ST_X2:  x2_q <= mul_r;
			ST_X3:  x3_q <= mul_r;
			ST_X5:  x5_q <= mul_r;
			ST_X7:  x7_q <= mul_r;
			ST_D3:  if (dv_done) acc_q <= a_q - dv_res;
			ST_D5:  if (dv_done) acc_q <= acc_q + dv_res;
			ST_D7: begin
				if (dv_done) begin
					case (job_q)
						3'd0:    coef_q.sh <= acc_q - dv_res;
						3'd1:    coef_q.ch <= acc_q - dv_res;
						3'd2:    coef_q.sv <= acc_q - dv_res;
						3'd3:    coef_q.cv <= acc_q - dv_res;
						3'd4:    coef_q.sw <= acc_q - dv_res;
						default: coef_q.cw <= acc_q - dv_res;
					endcase
				end
			end
			ST_PROD: begin
				case (pc_q)
					2'd0:    coef_q.chcv <= mul_r;
					2'd1:    coef_q.shcv <= mul_r;
					2'd2:    coef_q.chsv <= mul_r;
					default: coef_q.shsv <= mul_r;
				endcase
			end
			default: ;
		endcase
	end

	assign coef = coef_q;
	assign busy = (state_q != ST_DONE);

	a_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> busy)
		else $error("coef unit idle right after restart");
	a_dv_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		dv_cnt_q |-> dv_run_q)
		else $error("divider step without run");
	a_job_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_q <= 3'd5)
		else $error("coef job index out of range");

endmodule

// File: sv/perspective_vertex_projector_top.sv
// ----------------------------------------------------------------------------
// perspective_vertex_projector_top
// Projects Q16.16 model vertices to view depth and rotated screen points.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  s_*      in   s_tvalid / s_tready   tdata: pos_x, pos_y, pos_z; tlast: last_in
//  m_*      out  m_tvalid / m_tready   tdata: depth, screen_x, screen_y;
//                                      tuser: in_front; tlast: last_out
//  cfg_*    in   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One request per cycle while s_tready is high; the pipeline is the
//  39-stage reciprocal divider plus six multiply/add and register stages.
//  After reset and after each register write the coefficient sequencer runs
//  six sine series with constant divisions, then the four products, with
//  s_tready low.
//  Each stage holds while it is full and the stage after it cannot take its item; bubbles fill.
module perspective_vertex_projector_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // pos_x, pos_y, pos_z
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // depth, screen_x, screen_y
	output logic         m_tuser,   // in_front
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int NDV = pvp_pkg::DIV_BITS;
	localparam int NST = NDV + 6;
	localparam int IDV = 3;

	logic signed [31:0] horiz_q, vert_q, scrn_q, dist_q;
	pvp_pkg::coef_t     coef;
	logic               busy;
	logic               cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horiz_q <= pvp_pkg::RST_HORIZ;
			vert_q  <= pvp_pkg::RST_VERT;
			scrn_q  <= pvp_pkg::RST_SCRN;
			dist_q  <= pvp_pkg::RST_DIST;
		end else if (cfg_wr) begin
			case (cfg_index)
				pvp_pkg::REG_HORIZ: horiz_q <= cfg_data;
				pvp_pkg::REG_VERT:  vert_q  <= cfg_data;
				pvp_pkg::REG_SCRN:  scrn_q  <= cfg_data;
				pvp_pkg::REG_DIST:  dist_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	pvp_coef u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_wr),
		.horiz   (horiz_q),
		.vert    (vert_q),
		.scrn    (scrn_q),
		.coef    (coef),
		.busy    (busy)
	);

	logic [NST-1:0] vld_q;
	logic [NST:0]   rdy;
	logic           in_ok;

	always_comb begin
		rdy[NST] = m_tready;
		for (int k = NST - 1; k >= 0; k--)
			rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign s_tready = rdy[0] && !busy;
	assign in_ok    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0])
				vld_q[0] <= in_ok;
			for (int k = 1; k < NST; k++)
				if (rdy[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// stage 1: input register
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic               last_s1;
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			x_s1    <= s_tdata[31:0];
			y_s1    <= s_tdata[63:32];
			z_s1    <= s_tdata[95:64];
			last_s1 <= s_tlast;
		end
	end

	// stage 2: eight rotation products
	logic signed [31:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2, p7_s2, p8_s2;
	logic               last_s2;
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			p1_s2   <= pvp_pkg::fmul(x_s1, coef.chcv);
			p2_s2   <= pvp_pkg::fmul(y_s1, coef.shcv);
			p3_s2   <= pvp_pkg::fmul(z_s1, coef.sv);
			p4_s2   <= pvp_pkg::fmul(x_s1, coef.sh);
			p5_s2   <= pvp_pkg::fmul(y_s1, coef.ch);
			p6_s2   <= pvp_pkg::fmul(x_s1, coef.chsv);
			p7_s2   <= pvp_pkg::fmul(y_s1, coef.shsv);
			p8_s2   <= pvp_pkg::fmul(z_s1, coef.cv);
			last_s2 <= last_s1;
		end
	end

	// stage 3: view coordinates
	logic signed [31:0] zo_s3, xo_s3, yo_s3;
	logic               last_s3;
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			zo_s3   <= dist_q - p1_s2 - p2_s2 - p3_s2;
			xo_s3   <= p5_s2 - p4_s2;
			yo_s3   <= p8_s2 - p6_s2 - p7_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: reciprocal 100/depth, one quotient bit per stage
	logic [30:0]        dv_rem_s4 [NDV];
	logic [31:0]        dv_quo_s4 [NDV];
	logic [30:0]        dv_den_s4 [NDV];
	logic signed [31:0] dv_zo_s4  [NDV];
	logic signed [31:0] dv_xo_s4  [NDV];
	logic signed [31:0] dv_yo_s4  [NDV];
	logic               dv_last_s4[NDV];

	logic [30:0] src_rem [NDV];
	logic [31:0] src_quo [NDV];
	logic [30:0] src_den [NDV];
	logic [30:0] nxt_rem [NDV];
	logic [31:0] nxt_quo [NDV];
	logic [31:0] trial   [NDV];

	always_comb begin
		src_rem[0] = '0;
		src_quo[0] = '0;
		src_den[0] = zo_s3[30:0];
		for (int i = 1; i < NDV; i++) begin
			src_rem[i] = dv_rem_s4[i-1];
			src_quo[i] = dv_quo_s4[i-1];
			src_den[i] = dv_den_s4[i-1];
		end
		for (int i = 0; i < NDV; i++) begin
			trial[i] = {src_rem[i], pvp_pkg::DIV_DIVIDEND[NDV-1-i]};
			if (trial[i] >= {1'b0, src_den[i]}) begin
				nxt_rem[i] = 31'(trial[i] - {1'b0, src_den[i]});
				nxt_quo[i] = {src_quo[i][30:0], 1'b1};
			end else begin
				nxt_rem[i] = trial[i][30:0];
				nxt_quo[i] = {src_quo[i][30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[IDV]) begin
			dv_rem_s4[0]  <= nxt_rem[0];
			dv_quo_s4[0]  <= nxt_quo[0];
			dv_den_s4[0]  <= src_den[0];
			dv_zo_s4[0]   <= zo_s3;
			dv_xo_s4[0]   <= xo_s3;
			dv_yo_s4[0]   <= yo_s3;
			dv_last_s4[0] <= last_s3;
		end
		for (int i = 1; i < NDV; i++) begin
			if (rdy[IDV+i]) begin
				dv_rem_s4[i]  <= nxt_rem[i];
				dv_quo_s4[i]  <= nxt_quo[i];
				dv_den_s4[i]  <= src_den[i];
				dv_zo_s4[i]   <= dv_zo_s4[i-1];
				dv_xo_s4[i]   <= dv_xo_s4[i-1];
				dv_yo_s4[i]   <= dv_yo_s4[i-1];
				dv_last_s4[i] <= dv_last_s4[i-1];
			end
		end
	end

	// stage 5: perspective scale
	logic signed [31:0] mx_s5, my_s5, zo_s5;
	logic               last_s5;
	always_ff @(posedge clk) begin
		if (rdy[IDV+NDV]) begin
			mx_s5   <= pvp_pkg::fmul(dv_xo_s4[NDV-1], dv_quo_s4[NDV-1]);
			my_s5   <= pvp_pkg::fmul(dv_yo_s4[NDV-1], dv_quo_s4[NDV-1]);
			zo_s5   <= dv_zo_s4[NDV-1];
			last_s5 <= dv_last_s4[NDV-1];
		end
	end

	// stage 6: screen rotation products
	logic signed [31:0] ra_s6, rb_s6, rc_s6, rd_s6, zo_s6;
	logic               last_s6;
	always_ff @(posedge clk) begin
		if (rdy[IDV+NDV+1]) begin
			ra_s6   <= pvp_pkg::fmul(coef.cw, mx_s5);
			rb_s6   <= pvp_pkg::fmul(coef.sw, my_s5);
			rc_s6   <= pvp_pkg::fmul(coef.sw, mx_s5);
			rd_s6   <= pvp_pkg::fmul(coef.cw, my_s5);
			zo_s6   <= zo_s5;
			last_s6 <= last_s5;
		end
	end

	// stage 7: output register
	logic signed [31:0] rx, ry;
	logic               front;
	logic signed [31:0] depth_s7;
	logic signed [15:0] sx_s7, sy_s7;
	logic               front_s7, last_s7;

	always_comb begin
		rx    = ra_s6 - rb_s6 + pvp_pkg::FX_CX;
		ry    = pvp_pkg::FX_CY - (rc_s6 + rd_s6);
		front = !zo_s6[31] && (zo_s6 != 32'sd0);
	end

	always_ff @(posedge clk) begin
		if (rdy[NST-1]) begin
			depth_s7 <= zo_s6;
			sx_s7    <= front ? rx[31:16] : '1;
			sy_s7    <= front ? ry[31:16] : '1;
			front_s7 <= front;
			last_s7  <= last_s6;
		end
	end

	assign m_tvalid = vld_q[NST-1];
	assign m_tdata  = {sy_s7, sx_s7, depth_s7};
	assign m_tuser  = front_s7;
	assign m_tlast  = last_s7;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready)
		else $error("request accepted while coefficients are stale");
	a_front_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !depth_s7[31] && depth_s7 != 32'sd0)
		else $error("in_front with non-positive depth");
	a_behind_marks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> sx_s7 == -16'sd1 && sy_s7 == -16'sd1)
		else $error("behind point not marked");

endmodule

// File: bench/tb_perspective_vertex_projector_top.sv
// ----------------------------------------------------------------------------
// tb_perspective_vertex_projector_top
// Drives vertices through the projector under several idle and stall mixes,
// predicts depth and screen point in fixed point, and checks every result.
// ----------------------------------------------------------------------------
module tb_perspective_vertex_projector_top;

	typedef struct {
		logic signed [31:0] depth;
		logic [15:0]        sx;
		logic [15:0]        sy;
		logic               front;
		logic               last;
	} proj_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	perspective_vertex_projector_top DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#200_000_000;
		$display("FAIL perspective_vertex_projector_top");
		$finish;
	end

	logic signed [31:0] angle_h = pvp_pkg::RST_HORIZ, angle_v = pvp_pkg::RST_VERT;
	logic signed [31:0] angle_w = pvp_pkg::RST_SCRN, eye_dist = pvp_pkg::RST_DIST;
	proj_t expected_q[$];
	int errors = 0;
	int send_idle = 0, recv_stall = 0, hold_cycles = 0;

	function automatic longint wrap(longint v);
		return longint'(int'(v));
	endfunction

	function automatic longint qmul(longint a, longint b);
		return wrap((a * b) >>> 16);
	endfunction

	function automatic longint qdiv(longint a, longint b);
		if (b == 0) return 0;
		return wrap((a * 65536) / b);
	endfunction

	function automatic longint to_rad(logic signed [31:0] r);
		longint d;
		d = longint'(r) >>> 16;
		if (d < 0) d = 0;
		if (d > 360) d = 360;
		return (d * 3430 + 1) / 3;
	endfunction

	function automatic longint qsin(longint a);
		longint x2, x3, x5, x7, r;
		while (a > pvp_pkg::FX_PI) a = wrap(a - pvp_pkg::FX_TWO_PI);
		while (a < -pvp_pkg::FX_PI) a = wrap(a + pvp_pkg::FX_TWO_PI);
		x2 = qmul(a, a);
		x3 = qmul(x2, a);
		x5 = qmul(x3, x2);
		x7 = qmul(x5, x2);
		r = wrap(a - qdiv(x3, 6 * 65536));
		r = wrap(r + qdiv(x5, 120 * 65536));
		r = wrap(r - qdiv(x7, 5040 * 65536));
		return r;
	endfunction

	function automatic proj_t project_vertex(logic [95:0] pos, logic lst);
		longint rh, rv, rw, ch, sh, cv, sv, cw, sw, chcv, shcv, chsv, shsv;
		longint x, y, z, zo, xo, yo, inv, px, py, dx, dy, rx, ry;
		proj_t p;
		rh = to_rad(angle_h); rv = to_rad(angle_v); rw = to_rad(angle_w);
		ch = qsin(wrap(rh + pvp_pkg::FX_HALF_PI)); sh = qsin(rh);
		cv = qsin(wrap(rv + pvp_pkg::FX_HALF_PI)); sv = qsin(rv);
		cw = qsin(wrap(rw + pvp_pkg::FX_HALF_PI)); sw = qsin(rw);
		chcv = qmul(ch, cv); shcv = qmul(sh, cv);
		chsv = qmul(ch, sv); shsv = qmul(sh, sv);
		x = longint'($signed(pos[31:0]));
		y = longint'($signed(pos[63:32]));
		z = longint'($signed(pos[95:64]));
		zo = wrap(-qmul(x, chcv) - qmul(y, shcv) - qmul(z, sv) + eye_dist);
		p.depth = zo;
		p.sx = 16'hFFFF;
		p.sy = 16'hFFFF;
		p.front = 0;
		p.last = lst;
		if (zo > 0) begin
			xo = wrap(-qmul(x, sh) + qmul(y, ch));
			yo = wrap(-qmul(x, chsv) - qmul(y, shsv) + qmul(z, cv));
			inv = qdiv(100 * 65536, zo);
			px = wrap(qmul(xo, inv) + pvp_pkg::FX_CX);
			py = wrap(pvp_pkg::FX_CY - qmul(yo, inv));
			dx = wrap(px - pvp_pkg::FX_CX);
			dy = wrap(pvp_pkg::FX_CY - py);
			rx = wrap(qmul(cw, dx) - qmul(sw, dy) + pvp_pkg::FX_CX);
			ry = wrap(pvp_pkg::FX_CY - wrap(qmul(sw, dx) + qmul(cw, dy)));
			p.sx = rx[31:16];
			p.sy = ry[31:16];
			p.front = 1;
		end
		return p;
	endfunction

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 0;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		proj_t e;
		if (m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				e = expected_q.pop_front();
				if (m_tdata[31:0] !== e.depth || m_tdata[47:32] !== e.sx ||
						m_tdata[63:48] !== e.sy || m_tuser !== e.front ||
						m_tlast !== e.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp d=%h x=%h y=%h f=%b l=%b",
							e.depth, e.sx, e.sy, e.front, e.last,
							" got d=%h x=%h y=%h f=%b l=%b", m_tdata[31:0],
							m_tdata[47:32], m_tdata[63:48], m_tuser, m_tlast);
				end
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pvp_pkg::REG_HORIZ: angle_h = val;
			pvp_pkg::REG_VERT:  angle_v = val;
			pvp_pkg::REG_SCRN:  angle_w = val;
			pvp_pkg::REG_DIST:  eye_dist = val;
			default: ;
		endcase
	endtask

	task automatic send_vertex(logic [95:0] pos, logic lst);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= pos;
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(project_vertex(pos, lst));
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		s_tvalid <= 0;
		while (expected_q.size() != 0 && guard < 2_000_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: return $urandom_range(0, 32'h0280_0000) - 32'h0140_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return 360 << 16;
			default: return $urandom_range(0, 360) << 16 | $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	logic [31:0] stim_pos [12][3] = '{
		'{32'h0, 32'h0, 32'h0},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
		'{32'hFFFF_FFFF, 32'h0, 32'h0},
		'{32'h0001_0000, 32'h0002_0000, 32'h0003_0000},
		'{32'hFFF6_0000, 32'h000A_0000, 32'hFFF6_0000},
		'{32'h0020_0000, 32'h0, 32'h0},
		'{32'h0, 32'h0020_0000, 32'h0},
		'{32'h0, 32'h0, 32'h0020_0000},
		'{32'h0050_0000, 32'h0050_0000, 32'h0050_0000},
		'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
		'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}};

	initial begin
		logic [31:0] cfg_set [5][4];
		int n;
		proj_t e;
		cfg_set = '{
			'{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0},
			'{32'h7FFF_FFFF, 32'h0168_0000, 32'h8000_0000, 32'h8000_0000},
			'{32'h002D_8000, 32'h005A_0000, 32'h010E_0000, 32'h7FFF_FFFF},
			'{32'h00B4_0000, 32'hFFFF_0000, 32'h0169_0000, 32'h0064_0000},
			'{32'h001E_0000, 32'h0014_0000, 32'h0, 32'h001E_0000}};
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// reset registers: origin lands at depth 30, centre of screen
		s_tvalid <= 1;
		s_tdata <= '0;
		s_tlast <= 1;
		do @(posedge clk); while (!s_tready);
		e = project_vertex('0, 1);
		e.depth = 32'sh001E_0000; e.sx = 16'd160; e.sy = 16'd100;
		e.front = 1; e.last = 1;
		expected_q.push_back(e);
		for (int i = 0; i < 12; i++)
			send_vertex({stim_pos[i][2], stim_pos[i][1], stim_pos[i][0]}, i[0]);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			for (int r = 0; r < 4; r++)
				write_reg(r[1:0], ph < 5 ? cfg_set[ph][r] :
					(r == 3 ? rand_coord() : rand_angle()));
			cfg_valid <= 0;
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 76; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 76; end
				3: begin send_idle = 26; recv_stall = 26; end
				default: ;
			endcase
			if (ph == 4) hold_cycles = 300;
			n = (ph == 4) ? 60 : (ph < 5 ? 8 : 261);
			for (int i = 0; i < n; i++)
				send_vertex({rand_coord(), rand_coord(), rand_coord()}, $urandom_range(1));
			drain();
		end
		if (expected_q.size() != 0) begin
			errors++;
			$display("%0d results missing", expected_q.size());
		end
		if (errors == 0)
			$display("PASS perspective_vertex_projector_top");
		else
			$display("FAIL perspective_vertex_projector_top");
		$finish;
	end

endmodule

// File: filelist.f
sv/pvp_pkg.sv
sv/pvp_coef.sv
sv/perspective_vertex_projector_top.sv
bench/tb_perspective_vertex_projector_top.sv
